[rtl/oahi_pkg.sv]
// ----------------------------------------------------------------------------
// oahi_pkg
// Shared types and codes for the open-addressing hash insert block: request
// and result payloads, sequencer states, and the remainder unit interface.
// ----------------------------------------------------------------------------
package oahi_pkg;

    // Field widths of the payloads
    localparam int OP_W   = 2;
    localparam int KEY_W  = 31;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;
    localparam int MODE_W = 2;

    // Remainder unit: divisor up to 2047, reciprocal scaled by 2^KEY_W
    localparam int MOD_W  = 11;

    // Double hashing prime and its scaled reciprocal, rounded down
    localparam logic [MOD_W-1:0] DH_PRIME = 11'd7;
    localparam logic [KEY_W-1:0] DH_RECIP = KEY_W'((64'd1 << KEY_W) / 64'd7);

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_STORED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_READ    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CLEARED = 2'd3;

    // Probe modes (the unused code probes linearly)
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] slot_select;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slot_index;
        logic              slot_used;
        logic [KEY_W-1:0]  slot_key;
        logic [CNT_W-1:0]  probe_count;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [MOD_W-1:0] divisor;
        logic [KEY_W-1:0] recip;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] rem;
    } mod_rsp_t;

    typedef enum logic [1:0] {
        MOD_IDLE,
        MOD_MUL,
        MOD_FOLD,
        MOD_FIX
    } mod_phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_ISSUE,
        ST_READ_DONE,
        ST_MOD_HOME,
        ST_MOD_SEVEN,
        ST_MOD_STEP,
        ST_PROBE_ISSUE,
        ST_PROBE_CHECK
    } state_t;

endpackage

[rtl/oahi_mod_unit.sv]
// ----------------------------------------------------------------------------
// oahi_mod_unit
// Reciprocal remainder unit: multiply by the divisor's scaled reciprocal,
// fold the estimate back against the dividend, correct it with one subtract.
// Starts are taken mid-request too; one-cycle done pulse, remainder then held.
// ----------------------------------------------------------------------------
module oahi_mod_unit
    import oahi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int RW = MOD_W + 1;

    mod_phase_t         phase_reg, phase_next;
    logic               done_reg, done_next;
    logic [KEY_W-1:0]   dividend_reg, dividend_next;
    logic [KEY_W-1:0]   recip_reg, recip_next;
    logic [MOD_W-1:0]   divisor_reg, divisor_next;
    logic [RW-1:0]      quot_reg, quot_next;
    logic [RW-1:0]      est_reg, est_next;
    logic [MOD_W-1:0]   rem_reg, rem_next;
    logic [2*KEY_W-1:0] full_prod;
    logic [2*RW-1:0]    low_prod;
    logic [RW-1:0]      div_ext;
    logic [RW-1:0]      fix_diff;

    // The quotient estimate is low by at most one, so the folded value
    // lies below twice the divisor and only its low bits are needed
    assign full_prod = dividend_reg * recip_reg;
    assign div_ext   = {1'b0, divisor_reg};
    assign low_prod  = quot_reg * div_ext;
    assign fix_diff  = est_reg - div_ext;

    always_comb
    begin
        phase_next    = phase_reg;
        done_next     = 1'b0;
        dividend_next = dividend_reg;
        recip_next    = recip_reg;
        divisor_next  = divisor_reg;
        quot_next     = quot_reg;
        est_next      = est_reg;
        rem_next      = rem_reg;
        if (req.start)
        begin
            phase_next    = MOD_MUL;
            dividend_next = req.dividend;
            recip_next    = req.recip;
            divisor_next  = req.divisor;
        end
        else
        begin
            unique case (phase_reg)
                MOD_IDLE:
                begin
                    phase_next = MOD_IDLE;
                end
                MOD_MUL:
                begin
                    quot_next  = full_prod[KEY_W +: RW];
                    phase_next = MOD_FOLD;
                end
                MOD_FOLD:
                begin
                    est_next   = dividend_reg[RW-1:0] - low_prod[RW-1:0];
                    phase_next = MOD_FIX;
                end
                MOD_FIX:
                begin
                    if (est_reg >= div_ext)
                        rem_next = fix_diff[MOD_W-1:0];
                    else
                        rem_next = est_reg[MOD_W-1:0];
                    done_next  = 1'b1;
                    phase_next = MOD_IDLE;
                end
            endcase
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MOD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        recip_reg    <= recip_next;
        divisor_reg  <= divisor_next;
        quot_reg     <= quot_next;
        est_reg      <= est_next;
        rem_reg      <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

[rtl/open_addressing_hash_insert.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// Open-addressing hash table of TABLE_SIZE key slots with linear, quadratic
// or double-hashing probes, plus slot read and whole-table clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each insert, read
// or clear returns one result on result, marked by done for a single cycle,
// and the receiver must take it then; the result is on the ports in the
// first cycle that busy is low again. Operation code three is taken and
// dropped with no result. Busy stays high for the whole of a request. An
// insert first reduces the key by TABLE_SIZE in a shared remainder unit
// (reciprocal multiply, fold back, one correcting subtract); double
// hashing runs that unit twice more, for key mod 7 and to bring the step
// below TABLE_SIZE. Each probe then takes a slot memory read and then a
// check, up to TABLE_SIZE probes. A read issues a slot memory read and
// then returns the slot. A clear sweeps the valid memory one slot a
// cycle; the same sweep runs after reset (no result) while busy is high.
// Configuration writes are taken at any time through cfg_we; an insert
// uses the probe mode present when it is taken.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert
    import oahi_pkg::*;
#(
    parameter int TABLE_SIZE = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  request_t          request,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata
);

    localparam int AW        = $clog2(TABLE_SIZE);
    localparam int PW        = AW + 1;
    localparam int CW        = $clog2(TABLE_SIZE + 1);
    localparam int IDX_EXT_W = (PW > IDX_W) ? PW : IDX_W;
    localparam int CNT_EXT_W = (CW > CNT_W) ? CW : CNT_W;
    localparam int SEL_EXT_W = (AW > IDX_W) ? AW : IDX_W;

    localparam logic [PW-1:0]    SIZE_P      = PW'(TABLE_SIZE);
    localparam logic [CNT_W-1:0] FULL_COUNT  = CNT_W'(TABLE_SIZE % 32);
    localparam logic [KEY_W-1:0] RECIP_TABLE = KEY_W'((64'd1 << KEY_W) / 64'(TABLE_SIZE));

    state_t            state_reg, state_next;
    request_t          req_reg, req_next;
    logic [MODE_W-1:0] probe_mode_reg;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     delta_reg, delta_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_report_reg, clr_report_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;

    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    // Slot memories and their registered read port
    logic [KEY_W-1:0]  key_mem [TABLE_SIZE];
    logic              valid_mem [TABLE_SIZE];
    logic [KEY_W-1:0]  rd_key_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_valid_en;
    logic              wr_valid_bit;
    logic              wr_key_en;

    logic [PW-1:0]        pos_sum, pos_wrap;
    logic [PW-1:0]        delta_sum, delta_wrap;
    logic [IDX_EXT_W-1:0] pos_ext;
    logic [CNT_EXT_W-1:0] cnt_ext;
    logic [SEL_EXT_W-1:0] sel_ext;
    logic                 sel_ok;
    logic                 read_used;

    oahi_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Advance probe position and quadratic step, both kept below TABLE_SIZE
    assign pos_sum    = pos_reg + delta_reg;
    assign pos_wrap   = (pos_sum >= SIZE_P) ? (pos_sum - SIZE_P) : pos_sum;
    assign delta_sum  = delta_reg + PW'(2);
    assign delta_wrap = (delta_sum >= SIZE_P) ? (delta_sum - SIZE_P) : delta_sum;

    // Fit slot and count values to the result field widths
    assign pos_ext   = IDX_EXT_W'(pos_reg);
    assign cnt_ext   = CNT_EXT_W'(cnt_reg);
    assign sel_ext   = SEL_EXT_W'(req_reg.slot_select);
    assign sel_ok    = (32'(req_reg.slot_select) < 32'(TABLE_SIZE));
    assign read_used = sel_ok && rd_valid_reg;

    // Sequencer: next state, memory controls and result
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        delta_next      = delta_reg;
        cnt_next        = cnt_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        mod_req         = '0;
        rd_addr         = pos_reg[AW-1:0];
        wr_addr         = pos_reg[AW-1:0];
        wr_valid_en     = 1'b0;
        wr_valid_bit    = 1'b0;
        wr_key_en       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_valid_en   = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                    if (clr_report_reg)
                    begin
                        done_next        = 1'b1;
                        res_next         = '0;
                        res_next.status  = STAT_CLEARED;
                    end
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    unique case (request.operation)
                        OP_INSERT:
                        begin
                            mod_req.start    = 1'b1;
                            mod_req.dividend = request.key;
                            mod_req.divisor  = MOD_W'(TABLE_SIZE);
                            mod_req.recip    = RECIP_TABLE;
                            mode_next        = probe_mode_reg;
                            state_next       = ST_MOD_HOME;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ_ISSUE;
                        end
                        OP_CLEAR:
                        begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ_ISSUE:
            begin
                rd_addr    = sel_ext[AW-1:0];
                state_next = ST_READ_DONE;
            end

            ST_READ_DONE:
            begin
                done_next            = 1'b1;
                res_next.status      = STAT_READ;
                res_next.slot_index  = req_reg.slot_select;
                res_next.slot_used   = read_used;
                res_next.slot_key    = read_used ? rd_key_reg : '0;
                res_next.probe_count = '0;
                state_next           = ST_IDLE;
            end

            ST_MOD_HOME:
            begin
                if (mod_rsp.done)
                begin
                    pos_next = mod_rsp.rem[PW-1:0];
                    cnt_next = '0;
                    if (mode_reg == MODE_DOUBLE)
                    begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = req_reg.key;
                        mod_req.divisor  = DH_PRIME;
                        mod_req.recip    = DH_RECIP;
                        state_next       = ST_MOD_SEVEN;
                    end
                    else
                    begin
                        delta_next = PW'(1);
                        state_next = ST_PROBE_ISSUE;
                    end
                end
            end

            ST_MOD_SEVEN:
            begin
                // Reduce the step 7 - key mod 7 by the table size
                if (mod_rsp.done)
                begin
                    mod_req.start    = 1'b1;
                    mod_req.dividend = KEY_W'(DH_PRIME - mod_rsp.rem);
                    mod_req.divisor  = MOD_W'(TABLE_SIZE);
                    mod_req.recip    = RECIP_TABLE;
                    state_next       = ST_MOD_STEP;
                end
            end

            ST_MOD_STEP:
            begin
                if (mod_rsp.done)
                begin
                    delta_next = mod_rsp.rem[PW-1:0];
                    state_next = ST_PROBE_ISSUE;
                end
            end

            ST_PROBE_ISSUE:
            begin
                state_next = ST_PROBE_CHECK;
            end

            ST_PROBE_CHECK:
            begin
                if (!rd_valid_reg)
                begin
                    // Store the key in the free slot
                    wr_valid_en          = 1'b1;
                    wr_valid_bit         = 1'b1;
                    wr_key_en            = 1'b1;
                    done_next            = 1'b1;
                    res_next             = '0;
                    res_next.status      = STAT_STORED;
                    res_next.slot_index  = pos_ext[IDX_W-1:0];
                    res_next.probe_count = cnt_ext[CNT_W-1:0];
                    state_next           = ST_IDLE;
                end
                else if (cnt_reg == CW'(TABLE_SIZE - 1))
                begin
                    // No free slot along the probe sequence
                    done_next            = 1'b1;
                    res_next             = '0;
                    res_next.status      = STAT_FULL;
                    res_next.probe_count = FULL_COUNT;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                    pos_next = pos_wrap;
                    if (mode_reg == MODE_QUAD)
                        delta_next = delta_wrap;
                    state_next = ST_PROBE_ISSUE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the valid sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
            probe_mode_reg <= MODE_LINEAR;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
            if (cfg_we)
                probe_mode_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        mode_reg  <= mode_next;
        pos_reg   <= pos_next;
        delta_reg <= delta_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

    // Slot memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_valid_reg <= valid_mem[rd_addr];
        if (wr_valid_en)
            valid_mem[wr_addr] <= wr_valid_bit;
        if (wr_key_en)
            key_mem[wr_addr] <= req_reg.key;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

[verif/tb_open_addressing_hash_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_insert
// Self-checking bench for the open-addressing hash insert block. A shadow
// table predicts every insert, slot read and clear under each probe mode.
// A monitor compares each result against the oldest prediction, field by
// field. Directed cases cover wrap-around, collisions, quadratic dead ends,
// double-hash steps and the ignored opcode. Random phases then vary the
// probe mode, the sender idle rate and the clear rate.
// ----------------------------------------------------------------------------
module tb_open_addressing_hash_insert;
    import oahi_pkg::*;

    localparam int TABLE_SIZE    = 16;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 62;
    localparam int DH_STEP_BASE  = 7;

    localparam logic [OP_W-1:0]   OP_IGNORED  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    request_t          request;
    logic              done;
    result_t           result;
    logic              cfg_we;
    logic [MODE_W-1:0] cfg_wdata;

    // Shadow copy of the hash table and its probe mode
    logic [KEY_W-1:0]  shadow_keys [TABLE_SIZE];
    logic              shadow_valid [TABLE_SIZE];
    logic              shadow_written [TABLE_SIZE];
    logic [MODE_W-1:0] shadow_mode;

    result_t           pending_results [$];
    int                mismatch_count = 0;
    int                idle_pct = 0;
    int                watchdog = 0;

    open_addressing_hash_insert #(
        .TABLE_SIZE (TABLE_SIZE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the shadow table; return 1 when it yields a result
    function automatic bit apply_request(input request_t req, output result_t res);
        int unsigned home;
        int unsigned step;
        int unsigned offset;
        int unsigned pos;
        bit          placed;
        res    = '0;
        placed = 1'b0;
        case (req.operation)
            OP_INSERT:
            begin
                home = req.key % TABLE_SIZE;
                step = DH_STEP_BASE - (req.key % DH_STEP_BASE);
                for (int i = 0; i < TABLE_SIZE && !placed; i++)
                begin
                    case (shadow_mode)
                        MODE_QUAD:   offset = i * i;
                        MODE_DOUBLE: offset = i * step;
                        default:     offset = i;
                    endcase
                    pos = (home + offset) % TABLE_SIZE;
                    if (!shadow_valid[pos])
                    begin
                        shadow_keys[pos]    = req.key;
                        shadow_valid[pos]   = 1'b1;
                        shadow_written[pos] = 1'b1;
                        res.status          = STAT_STORED;
                        res.slot_index      = IDX_W'(pos);
                        res.probe_count     = CNT_W'(i);
                        placed              = 1'b1;
                    end
                end
                if (!placed)
                begin
                    res.status      = STAT_FULL;
                    res.probe_count = CNT_W'(TABLE_SIZE);
                end
                return 1'b1;
            end
            OP_READ:
            begin
                res.status     = STAT_READ;
                res.slot_index = req.slot_select;
                if (req.slot_select < TABLE_SIZE && shadow_valid[req.slot_select])
                begin
                    res.slot_used = 1'b1;
                    res.slot_key  = shadow_keys[req.slot_select];
                end
                return 1'b1;
            end
            OP_CLEAR:
            begin
                for (int s = 0; s < TABLE_SIZE; s++)
                    shadow_valid[s] = 1'b0;
                res.status = STAT_CLEARED;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic request_t make_request(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] key,
                                              input logic [IDX_W-1:0] sel);
        request_t req;
        req.operation   = op;
        req.key         = key;
        req.slot_select = sel;
        return req;
    endfunction

    // Build one random request; reads mostly target slots written at least
    // once and sometimes any slot
    function automatic request_t random_request(input int clear_pct);
        request_t    req;
        int          roll;
        int unsigned filled [$];
        req.operation   = OP_INSERT;
        req.key         = KEY_W'($urandom);
        req.slot_select = IDX_W'($urandom);
        for (int s = 0; s < TABLE_SIZE; s++)
            if (shadow_written[s])
                filled.push_back(s);
        roll = $urandom_range(99);
        if (roll < 5)
            req.operation = OP_IGNORED;
        else if (roll < 5 + clear_pct)
            req.operation = OP_CLEAR;
        else if (roll < 35 + clear_pct)
        begin
            req.operation = OP_READ;
            if (filled.size() != 0 && $urandom_range(3) != 0)
                req.slot_select = IDX_W'(filled[$urandom_range(filled.size() - 1)]);
        end
        else
        begin
            // Shape keys toward collisions, duplicates and extremes
            roll = $urandom_range(99);
            if (roll < 35)
                ;
            else if (roll < 60)
                req.key[IDX_W-1:0] = IDX_W'($urandom_range(3));
            else if (roll < 75 && filled.size() != 0)
                req.key = shadow_keys[filled[$urandom_range(filled.size() - 1)]];
            else if (roll < 87)
                req.key = KEY_W'($urandom_range(40));
            else
                req.key = {KEY_W{1'b1}} - KEY_W'($urandom_range(20));
        end
        return req;
    endfunction

    // Hold off at random, then present one request until the block takes it
    task automatic send_request(input request_t req);
        result_t want;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        if (apply_request(req, want))
            pending_results.push_back(want);
    endtask

    // Stop sending and wait for every predicted result
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write the probe mode once the block has gone quiet
    task automatic set_probe_mode(input logic [MODE_W-1:0] mode);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we      <= 1'b0;
        shadow_mode  = mode;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d slot %0d",
                             result.status, result.slot_index);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status",      result.status,      want.status);
                check_field("slot_index",  result.slot_index,  want.slot_index);
                check_field("slot_used",   result.slot_used,   want.slot_used);
                check_field("slot_key",    result.slot_key,    want.slot_key);
                check_field("probe_count", result.probe_count, want.probe_count);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            watchdog <= 0;
        else if (watchdog >= WATCHDOG_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            watchdog <= watchdog + 1;
    end

    // Linear probing from the reset mode: wrap-around, collisions, reads, clear
    task automatic test_linear_basics();
        send_request(make_request(OP_INSERT, 31'd0, 4'd0));
        send_request(make_request(OP_INSERT, {KEY_W{1'b1}}, 4'd0));
        send_request(make_request(OP_INSERT, 31'd16, 4'd15));
        send_request(make_request(OP_INSERT, 31'd31, 4'd0));
        send_request(make_request(OP_READ, 31'd0, 4'd0));
        send_request(make_request(OP_READ, {KEY_W{1'b1}}, 4'd15));
        send_request(make_request(OP_READ, 31'd5, 4'd2));
        send_request(make_request(OP_READ, 31'd0, 4'd1));
        // ignored opcode: no result, table untouched
        send_request(make_request(OP_IGNORED, {KEY_W{1'b1}}, 4'd15));
        send_request(make_request(OP_CLEAR, {KEY_W{1'b1}}, 4'd15));
        send_request(make_request(OP_READ, 31'd0, 4'd15));
        send_request(make_request(OP_INSERT, 31'd15, 4'd0));
    endtask

    // Quadratic probing: four slots reachable from one home, fifth insert reports full
    task automatic test_quadratic_coverage();
        set_probe_mode(MODE_QUAD);
        send_request(make_request(OP_CLEAR, 31'd0, 4'd0));
        send_request(make_request(OP_INSERT, 31'd5, 4'd0));
        send_request(make_request(OP_INSERT, 31'd21, 4'd0));
        send_request(make_request(OP_INSERT, 31'd37, 4'd0));
        send_request(make_request(OP_INSERT, 31'd53, 4'd0));
        send_request(make_request(OP_INSERT, 31'd69, 4'd0));
        send_request(make_request(OP_READ, 31'd0, 4'd9));
    endtask

    // Double hashing: steps of six, four and two from the same home
    task automatic test_double_hashing();
        set_probe_mode(MODE_DOUBLE);
        send_request(make_request(OP_CLEAR, 31'd0, 4'd0));
        send_request(make_request(OP_INSERT, 31'd1, 4'd0));
        send_request(make_request(OP_INSERT, 31'd17, 4'd0));
        send_request(make_request(OP_INSERT, 31'd33, 4'd0));
        send_request(make_request(OP_READ, 31'd0, 4'd5));
    endtask

    // Random phases over every probe mode and idle rate
    task automatic test_random_traffic();
        request_t req;
        int       sent;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 4)
                0:       set_probe_mode(MODE_LINEAR);
                1:       set_probe_mode(MODE_QUAD);
                2:       set_probe_mode(MODE_DOUBLE);
                default: set_probe_mode(MODE_UNUSED);
            endcase
            // the receiver cannot stall, so only the sender rate varies
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 79;
                default: idle_pct = 15;
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                req = random_request((phase % 2 == 0) ? 2 : 8);
                send_request(req);
                if (req.operation != OP_IGNORED)
                    sent++;
                if ($urandom_range(99) == 0)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = MODE_LINEAR;
        for (int s = 0; s < TABLE_SIZE; s++)
        begin
            shadow_keys[s]    = '0;
            shadow_valid[s]   = 1'b0;
            shadow_written[s] = 1'b0;
        end
        shadow_mode = MODE_LINEAR;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_linear_basics();
        test_quadratic_coverage();
        test_double_hashing();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
